// ===== rtl/hds_pkg.sv =====
// ----------------------------------------------------------------------------
// Heat diffusion stencil package
// Shared types and constants for the 1-D heat diffusion relaxation block.
// ----------------------------------------------------------------------------
package hds_pkg;

  // Fixed widths of the external fields.
  localparam int unsigned EXT_TEMP_W = 32;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned SWEEP_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned POINTS_W   = 7;
  localparam int unsigned TOL_W      = 32;
  localparam int unsigned SUM_W      = 38;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  // Smallest grid that still has one interior point.
  localparam int unsigned MIN_POINTS = 3;

  // Register reset values.
  localparam logic [POINTS_W-1:0] POINTS_RESET = 7'd32;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd16384;
  localparam logic [SWEEP_W-1:0]  MAX_IT_RESET = 16'd1000;
  localparam logic [TOL_W-1:0]    TOL_RESET    = 32'd66;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINTS_IN_USE      = 2'd0,
    CFG_DIFFUSION_GAIN     = 2'd1,
    CFG_MAX_ITERATIONS     = 2'd2,
    CFG_RESIDUAL_TOLERANCE = 2'd3
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SWEEP,
    ST_RD_PRIOR,
    ST_RD_CENTER,
    ST_LAP,
    ST_MUL,
    ST_UPD,
    ST_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } hds_state_e;

  // Step enables for the shared relaxation unit.
  typedef struct packed {
    logic lap_en;
    logic mul_en;
  } hds_relax_step_t;

  // Request payload: boundary temperatures.
  typedef struct packed {
    logic signed [EXT_TEMP_W-1:0] left_temp;
    logic signed [EXT_TEMP_W-1:0] right_temp;
  } hds_in_t;

  // Result payload: one grid point.
  typedef struct packed {
    logic signed [EXT_TEMP_W-1:0] temperature;
    logic [INDEX_W-1:0]           point_index;
    logic                         last_point;
    logic                         converged;
    logic [SWEEP_W-1:0]           sweeps_done;
  } hds_out_t;

endpackage

// ===== rtl/hds_stream_if.sv =====
// ----------------------------------------------------------------------------
// Heat diffusion stream interface
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface hds_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

// ===== rtl/hds_relax_unit.sv =====
// ----------------------------------------------------------------------------
// Heat diffusion relaxation unit
// Shared point update: Laplacian, gain multiply, rounding, saturation and
// absolute change, split over two registered steps.
// ----------------------------------------------------------------------------
module hds_relax_unit #(
  parameter int unsigned TEMP_WIDTH = 32
) (
  input  logic                           clk_i,
  input  hds_pkg::hds_relax_step_t       step_i,
  input  logic signed [TEMP_WIDTH-1:0]   left_i,
  input  logic signed [TEMP_WIDTH-1:0]   center_i,
  input  logic signed [TEMP_WIDTH-1:0]   right_i,
  input  logic [hds_pkg::GAIN_W-1:0]     gain_i,
  output logic signed [TEMP_WIDTH-1:0]   new_temp_o,
  output logic [TEMP_WIDTH-1:0]          abs_change_o
);

  import hds_pkg::*;

  localparam int unsigned W  = TEMP_WIDTH;
  localparam int unsigned LW = W + 2;
  localparam int unsigned PW = LW + GAIN_W;
  localparam int unsigned SW = W + 3;

  localparam logic signed [SW-1:0] SAT_MAX = {{4{1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {{4{1'b1}}, {(W-1){1'b0}}};
  localparam logic [PW-1:0]        ROUND_HALF = {{LW{1'b0}}, 1'b1, {(GAIN_W-1){1'b0}}};

  logic signed [LW-1:0] lap;
  logic [LW-1:0]        mag_d;
  logic [LW-1:0]        mag_q;
  logic                 neg_q;
  logic                 neg2_q;
  logic [PW-1:0]        prod_q;
  logic [PW-1:0]        rounded;
  logic [LW-1:0]        quot;
  logic signed [SW-1:0] center_ext;
  logic signed [SW-1:0] quot_ext;
  logic signed [SW-1:0] sum;
  logic signed [W:0]    diff;
  logic [W:0]           diff_abs;

  // Laplacian left + right - 2*center, as sign and magnitude.
  assign lap = {{2{left_i[W-1]}}, left_i} + {{2{right_i[W-1]}}, right_i}
             - {center_i[W-1], center_i, 1'b0};
  assign mag_d = lap[LW-1] ? LW'(-lap) : LW'(lap);

  always_ff @(posedge clk_i) begin
    if (step_i.lap_en) begin
      neg_q <= lap[LW-1];
      mag_q <= mag_d;
    end
    if (step_i.mul_en) begin
      neg2_q <= neg_q;
      prod_q <= PW'(mag_q) * PW'(gain_i);
    end
  end

  // Round to nearest, ties away from zero, on the magnitude.
  assign rounded = prod_q + ROUND_HALF;
  assign quot    = rounded[PW-1:GAIN_W];

  // Apply the change and saturate to the grid range.
  assign center_ext = {{3{center_i[W-1]}}, center_i};
  assign quot_ext   = {1'b0, quot};
  assign sum        = neg2_q ? (center_ext - quot_ext) : (center_ext + quot_ext);

  always_comb begin
    priority if (sum > SAT_MAX) begin
      new_temp_o = SAT_MAX[W-1:0];
    end else if (sum < SAT_MIN) begin
      new_temp_o = SAT_MIN[W-1:0];
    end else begin
      new_temp_o = sum[W-1:0];
    end
  end

  // Absolute change of this point.
  assign diff         = {new_temp_o[W-1], new_temp_o} - {center_i[W-1], center_i};
  assign diff_abs     = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
  assign abs_change_o = diff_abs[W-1:0];

endmodule

// ===== rtl/heat_diffusion_stencil_1d.sv =====
// ----------------------------------------------------------------------------
// Heat diffusion stencil, 1-D
// Explicit FTCS relaxation of a 1-D grid between two fixed boundaries.
// ----------------------------------------------------------------------------
// Each request carries the left and right boundary temperatures and starts
// one run. The run writes the grid (P points) point by point, then sweeps it
// until the summed absolute change drops below the tolerance or the sweep
// limit is reached, and finally returns one result per point in order. All
// interior points go through one shared relaxation unit and one grid memory
// with one write port and one read port, so each interior point goes through
// the Laplacian, the multiply and the write-back in turn, and each sweep adds
// sweep setup and the convergence check. Each result is read from the grid
// memory, loaded into the result register and held until the result side
// takes it. The block takes no new request until the last result of a run
// has been delivered. The grid memory needs no clearing after reset.
module heat_diffusion_stencil_1d #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned TEMP_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hds_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hds_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  hds_stream_if.sink                       in_req_i,
  hds_stream_if.source                     res_o
);

  import hds_pkg::*;

  localparam int unsigned W   = TEMP_WIDTH;
  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned PW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned EW  = ((W > EXT_TEMP_W) ? W : EXT_TEMP_W) + 1;
  localparam int unsigned CW  = ((W > SUM_W) ? W : SUM_W) + 1;

  localparam logic signed [EW-1:0] GRID_MAX = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [EW-1:0] GRID_MIN = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [EW-1:0] EXT_MAX  =
    {{(EW-EXT_TEMP_W+1){1'b0}}, {(EXT_TEMP_W-1){1'b1}}};
  localparam logic signed [EW-1:0] EXT_MIN  =
    {{(EW-EXT_TEMP_W+1){1'b1}}, {(EXT_TEMP_W-1){1'b0}}};
  localparam logic [CW-1:0]        SUM_MAX  = {{(CW-SUM_W){1'b0}}, {SUM_W{1'b1}}};
  localparam logic [POINTS_W-1:0]  MAXP     = POINTS_W'(MAX_POINTS);
  localparam logic [POINTS_W-1:0]  MINP     = POINTS_W'(MIN_POINTS);

  // Clamp a boundary input to the grid range.
  function automatic logic signed [W-1:0] clamp_in(input logic signed [EXT_TEMP_W-1:0] v);
    logic signed [EW-1:0] e;
    e = {{(EW-EXT_TEMP_W){v[EXT_TEMP_W-1]}}, v};
    if (e > GRID_MAX) begin
      e = GRID_MAX;
    end else if (e < GRID_MIN) begin
      e = GRID_MIN;
    end
    return e[W-1:0];
  endfunction

  // Clamp a grid value to the result field range.
  function automatic logic signed [EXT_TEMP_W-1:0] clamp_out(input logic signed [W-1:0] v);
    logic signed [EW-1:0] e;
    e = {{(EW-W){v[W-1]}}, v};
    if (e > EXT_MAX) begin
      e = EXT_MAX;
    end else if (e < EXT_MIN) begin
      e = EXT_MIN;
    end
    return e[EXT_TEMP_W-1:0];
  endfunction

  // Configuration registers.
  logic [POINTS_W-1:0] points_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [SWEEP_W-1:0]  max_it_q;
  logic [TOL_W-1:0]    tol_q;

  // Sequencer state.
  hds_state_e          state_q, state_d;
  logic [PW-1:0]       idx_q, idx_d;
  logic [PW-1:0]       pts_q, pts_d;
  logic [SWEEP_W-1:0]  sweep_q, sweep_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                conv_q, conv_d;

  // Datapath registers.
  logic signed [W-1:0] left_q, left_d;
  logic signed [W-1:0] right_q, right_d;
  logic signed [W-1:0] prior_q, prior_d;
  logic signed [W-1:0] center_q, center_d;
  logic signed [W-1:0] nbr_q, nbr_d;
  hds_out_t            res_q, res_d;

  // Grid memory.
  logic signed [W-1:0] grid_mem [MAX_POINTS];
  logic signed [W-1:0] rdata_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic signed [W-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;

  // Relaxation unit hookup.
  hds_relax_step_t     step;
  logic signed [W-1:0] new_temp;
  logic [W-1:0]        abs_change;

  logic [PW:0]         idx_p1;
  logic [PW:0]         idx_p2;
  logic [PW:0]         pts_ext;
  logic [CW-1:0]       sum_next;

  assign idx_p1   = {1'b0, idx_q} + (PW+1)'(1);
  assign idx_p2   = {1'b0, idx_q} + (PW+1)'(2);
  assign pts_ext  = {1'b0, pts_q};
  assign sum_next = CW'(sum_q) + CW'(abs_change);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= POINTS_RESET;
      gain_q   <= GAIN_RESET;
      max_it_q <= MAX_IT_RESET;
      tol_q    <= TOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_POINTS_IN_USE:      points_q <= cfg_data_i[POINTS_W-1:0];
        CFG_DIFFUSION_GAIN:     gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_MAX_ITERATIONS:     max_it_q <= cfg_data_i[SWEEP_W-1:0];
        CFG_RESIDUAL_TOLERANCE: tol_q    <= cfg_data_i[TOL_W-1:0];
      endcase
    end
  end

  // Grid memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= grid_mem[mem_raddr];
    end
  end

  // Shared point update.
  hds_relax_unit #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_relax (
    .clk_i        (clk_i),
    .step_i       (step),
    .left_i       (prior_q),
    .center_i     (center_q),
    .right_i      (rdata_q),
    .gain_i       (gain_q),
    .new_temp_o   (new_temp),
    .abs_change_o (abs_change)
  );

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      pts_q   <= PW'(MIN_POINTS);
      sweep_q <= '0;
      sum_q   <= '0;
      conv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pts_q   <= pts_d;
      sweep_q <= sweep_d;
      sum_q   <= sum_d;
      conv_q  <= conv_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    left_q   <= left_d;
    right_q  <= right_d;
    prior_q  <= prior_d;
    center_q <= center_d;
    nbr_q    <= nbr_d;
    res_q    <= res_d;
  end

  assign in_req_i.ready = (state_q == ST_IDLE);
  assign res_o.valid    = (state_q == ST_EMIT_WAIT);
  assign res_o.data     = res_q;

  // Sequencer: next state, memory control and datapath updates.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pts_d     = pts_q;
    sweep_d   = sweep_q;
    sum_d     = sum_q;
    conv_d    = conv_q;
    left_d    = left_q;
    right_d   = right_q;
    prior_d   = prior_q;
    center_d  = center_q;
    nbr_d     = nbr_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = new_temp;
    mem_re    = 1'b0;
    mem_raddr = idx_q[AW-1:0];
    step      = '0;

    unique case (state_q)
      // Take a request and latch the clamped run setup.
      ST_IDLE: begin
        if (in_req_i.valid) begin
          priority if (points_q < MINP) begin
            pts_d = PW'(MIN_POINTS);
          end else if (points_q > MAXP) begin
            pts_d = PW'(MAX_POINTS);
          end else begin
            pts_d = points_q[PW-1:0];
          end
          left_d  = clamp_in(in_req_i.data.left_temp);
          right_d = clamp_in(in_req_i.data.right_temp);
          idx_d   = '0;
          sweep_d = '0;
          sum_d   = '0;
          conv_d  = 1'b0;
          state_d = ST_INIT;
        end
      end

      // Write boundaries and zero the interior, one point per cycle.
      ST_INIT: begin
        mem_we = 1'b1;
        priority if (idx_q == '0) begin
          mem_wdata = left_q;
        end else if (idx_p1 == pts_ext) begin
          mem_wdata = right_q;
        end else begin
          mem_wdata = '0;
        end
        if (idx_p1 == pts_ext) begin
          state_d = ST_SWEEP;
        end else begin
          idx_d = idx_p1[PW-1:0];
        end
      end

      // Start a sweep unless the sweep limit is reached.
      ST_SWEEP: begin
        if (sweep_q >= max_it_q) begin
          idx_d   = '0;
          state_d = ST_EMIT_RD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          sum_d     = '0;
          state_d   = ST_RD_PRIOR;
        end
      end

      ST_RD_PRIOR: begin
        prior_d   = rdata_q;
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
        idx_d     = PW'(1);
        state_d   = ST_RD_CENTER;
      end

      ST_RD_CENTER: begin
        center_d  = rdata_q;
        mem_re    = 1'b1;
        mem_raddr = idx_p1[AW-1:0];
        state_d   = ST_LAP;
      end

      // Right neighbor has arrived: form the Laplacian.
      ST_LAP: begin
        nbr_d       = rdata_q;
        step.lap_en = 1'b1;
        state_d     = ST_MUL;
      end

      ST_MUL: begin
        step.mul_en = 1'b1;
        state_d     = ST_UPD;
      end

      // Write the new value back, accumulate the change, shift the window.
      ST_UPD: begin
        mem_we   = 1'b1;
        sum_d    = (sum_next > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_next[SUM_W-1:0];
        prior_d  = center_q;
        center_d = nbr_q;
        if (idx_p2 < pts_ext) begin
          idx_d     = idx_p1[PW-1:0];
          mem_re    = 1'b1;
          mem_raddr = idx_p2[AW-1:0];
          state_d   = ST_LAP;
        end else begin
          state_d = ST_CHK;
        end
      end

      // End of sweep: count it and test for convergence.
      ST_CHK: begin
        sweep_d = sweep_q + SWEEP_W'(1);
        if (sum_q < SUM_W'(tol_q)) begin
          conv_d  = 1'b1;
          idx_d   = '0;
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_SWEEP;
        end
      end

      ST_EMIT_RD: begin
        mem_re  = 1'b1;
        state_d = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        res_d.temperature = clamp_out(rdata_q);
        res_d.point_index = INDEX_W'(idx_q);
        res_d.last_point  = (idx_p1 == pts_ext);
        res_d.converged   = conv_q;
        res_d.sweeps_done = sweep_q;
        state_d           = ST_EMIT_WAIT;
      end

      // Hold the result until it is taken.
      ST_EMIT_WAIT: begin
        if (res_o.ready) begin
          if (idx_p1 == pts_ext) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_p1[PW-1:0];
            state_d = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/sv/hds_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heat diffusion result checker
// Watches the request and result channels and the register write port. For
// each accepted request it relaxes its own copy of the grid and queues the
// grid points that the block should return. It then compares each returned
// point field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module hds_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  hds_stream_if                          req_mon,
  hds_stream_if                          res_mon,
  output int                             mismatch_count_o,
  output int                             points_pending_o,
  output int                             points_checked_o
);

  import hds_pkg::*;

  localparam int unsigned GRID_MAX    = 64;
  localparam longint      SUM_LIMIT   = (64'sd1 <<< 38) - 1;
  localparam longint      TEMP_HI     = 64'sd2147483647;
  localparam longint      TEMP_LO     = -64'sd2147483648;

  // Shadow copy of the configuration registers.
  logic [POINTS_W-1:0] cfg_points;
  logic [GAIN_W-1:0]   cfg_gain;
  logic [SWEEP_W-1:0]  cfg_max_sweeps;
  logic [TOL_W-1:0]    cfg_tolerance;

  // Grid points still owed by the block, oldest first.
  hds_out_t pending_grid_points[$];

  // Saturates a wide temperature to the signed 32-bit range.
  function automatic logic signed [EXT_TEMP_W-1:0] saturate_temp(input longint value);
    if (value > TEMP_HI) return TEMP_HI[EXT_TEMP_W-1:0];
    if (value < TEMP_LO) return TEMP_LO[EXT_TEMP_W-1:0];
    return value[EXT_TEMP_W-1:0];
  endfunction

  // One FTCS point update, rounding the gain product half away from zero.
  function automatic logic signed [EXT_TEMP_W-1:0] relax_point(
    input logic signed [EXT_TEMP_W-1:0] left,
    input logic signed [EXT_TEMP_W-1:0] center,
    input logic signed [EXT_TEMP_W-1:0] right
  );
    longint laplacian;
    longint magnitude;
    longint gain;
    longint scaled;
    laplacian = longint'(left) + longint'(right) - 2 * longint'(center);
    magnitude = (laplacian < 0) ? -laplacian : laplacian;
    gain      = cfg_gain;
    scaled    = (magnitude >>> 16) * gain + (((magnitude & 64'hFFFF) * gain + 64'h8000) >>> 16);
    return saturate_temp(longint'(center) + ((laplacian < 0) ? -scaled : scaled));
  endfunction

  // Runs one whole relaxation and queues the final grid.
  function automatic void relax_grid_run(input hds_in_t req);
    logic signed [EXT_TEMP_W-1:0] grid[GRID_MAX];
    logic signed [EXT_TEMP_W-1:0] left_old;
    logic signed [EXT_TEMP_W-1:0] center_old;
    logic signed [EXT_TEMP_W-1:0] updated;
    longint                       change_total;
    longint                       step;
    int unsigned                  npts;
    int unsigned                  sweeps;
    bit                           settled;
    hds_out_t                     point;
    npts = cfg_points;
    if (npts < MIN_POINTS) npts = MIN_POINTS;
    if (npts > GRID_MAX) npts = GRID_MAX;
    for (int i = 0; i < GRID_MAX; i++) grid[i] = '0;
    grid[0]      = req.left_temp;
    grid[npts-1] = req.right_temp;
    sweeps  = 0;
    settled = 1'b0;

    // Jacobi sweeps: the left neighbor is taken from before its update.
    while (sweeps < cfg_max_sweeps && !settled) begin
      left_old     = grid[0];
      change_total = 0;
      for (int i = 1; i + 1 < npts; i++) begin
        center_old = grid[i];
        updated    = relax_point(left_old, center_old, grid[i+1]);
        step       = longint'(updated) - longint'(center_old);
        if (step < 0) step = -step;
        change_total += step;
        if (change_total > SUM_LIMIT) change_total = SUM_LIMIT;
        left_old = center_old;
        grid[i]  = updated;
      end
      sweeps++;
      if (change_total < longint'(cfg_tolerance)) settled = 1'b1;
    end

    // One result per grid point, in order.
    for (int i = 0; i < npts; i++) begin
      point.temperature = grid[i];
      point.point_index = INDEX_W'(i);
      point.last_point  = (i == npts - 1);
      point.converged   = settled;
      point.sweeps_done = SWEEP_W'(sweeps);
      pending_grid_points = {pending_grid_points, point};
    end
  endfunction

  // Compares one field and reports a difference.
  function automatic bit field_matches(input string field, input int index,
                                       input longint want, input longint got);
    if (want == got) return 1'b1;
    $display("%0t: point %0d %s mismatch, expected %0d got %0d",
             $time, index, field, want, got);
    return 1'b0;
  endfunction

  // Register writes, result checks and request predictions.
  always @(posedge clk_i or negedge rst_ni) begin
    hds_out_t want;
    hds_out_t got;
    bit       all_ok;
    if (!rst_ni) begin
      cfg_points       = POINTS_RESET;
      cfg_gain         = GAIN_RESET;
      cfg_max_sweeps   = MAX_IT_RESET;
      cfg_tolerance    = TOL_RESET;
      mismatch_count_o = 0;
      points_checked_o = 0;
      points_pending_o = 0;
      pending_grid_points.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_POINTS_IN_USE:      cfg_points     = cfg_data_i[POINTS_W-1:0];
          CFG_DIFFUSION_GAIN:     cfg_gain       = cfg_data_i[GAIN_W-1:0];
          CFG_MAX_ITERATIONS:     cfg_max_sweeps = cfg_data_i[SWEEP_W-1:0];
          CFG_RESIDUAL_TOLERANCE: cfg_tolerance  = cfg_data_i[TOL_W-1:0];
          default: ;
        endcase
      end

      if (res_mon.valid && res_mon.ready) begin
        got = res_mon.data;
        if (pending_grid_points.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected result, expected none got point %0d temperature %0d",
                   $time, got.point_index, got.temperature);
        end else begin
          want   = pending_grid_points.pop_front();
          all_ok = 1'b1;
          all_ok &= field_matches("temperature", want.point_index,
                                  want.temperature, got.temperature);
          all_ok &= field_matches("point_index", want.point_index,
                                  want.point_index, got.point_index);
          all_ok &= field_matches("last_point", want.point_index,
                                  want.last_point, got.last_point);
          all_ok &= field_matches("converged", want.point_index,
                                  want.converged, got.converged);
          all_ok &= field_matches("sweeps_done", want.point_index,
                                  want.sweeps_done, got.sweeps_done);
          if (!all_ok) mismatch_count_o++;
          points_checked_o++;
        end
      end

      if (req_mon.valid && req_mon.ready) relax_grid_run(req_mon.data);
      points_pending_o = pending_grid_points.size();
    end
  end

endmodule

// ===== tb/sv/heat_diffusion_stencil_1d_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heat diffusion stencil testbench
// Drives boundary requests and register settings into the 1-D relaxation
// block, from directed corner cases to random runs under several idle and
// stall patterns, and judges by the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_1d_test;

  import hds_pkg::*;

  localparam int QUIET_LIMIT     = 20000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int TAIL_CYCLES     = 20;
  localparam int HOLD_OFF_CYCLES = 1000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  hds_stream_if #(.payload_t(hds_in_t))  boundary_req ();
  hds_stream_if #(.payload_t(hds_out_t)) point_res ();

  int mismatch_count;
  int points_pending;
  int points_checked;
  int runs_sent;
  int settings_used;
  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int quiet_cycles;
  bit hold_off_armed;

  heat_diffusion_stencil_1d DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (boundary_req),
    .res_o       (point_res)
  );

  hds_result_checker CHECK (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_mon          (boundary_req),
    .res_mon          (point_res),
    .mismatch_count_o (mismatch_count),
    .points_pending_o (points_pending),
    .points_checked_o (points_checked)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: random stalls, or a long hold-off when one is armed.
  initial begin
    point_res.ready = 1'b0;
    hold_left       = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        hold_left      = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        point_res.ready <= 1'b0;
        hold_left--;
      end else begin
        point_res.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if ((boundary_req.valid && boundary_req.ready) || (point_res.valid && point_res.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one request and returns at the falling edge after it is taken.
  // Valid stays high so that a following request can go back to back.
  task automatic send_request(input logic signed [EXT_TEMP_W-1:0] left,
                              input logic signed [EXT_TEMP_W-1:0] right);
    while ($urandom_range(99) < send_idle_pct) begin
      boundary_req.valid <= 1'b0;
      @(negedge clk_i);
    end
    boundary_req.valid <= 1'b1;
    boundary_req.data  <= '{left_temp: left, right_temp: right};
    do @(posedge clk_i); while (!boundary_req.ready);
    @(negedge clk_i);
    runs_sent++;
  endtask

  // Stops offering and waits until every queued point has been returned.
  task automatic drain_results();
    boundary_req.valid <= 1'b0;
    @(negedge clk_i);
    while (points_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e index, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(negedge clk_i);
  endtask

  // Writes all four registers while the block is idle.
  task automatic set_grid(input logic [POINTS_W-1:0] points, input logic [GAIN_W-1:0] gain,
                          input logic [SWEEP_W-1:0] sweep_cap, input logic [TOL_W-1:0] tol);
    drain_results();
    write_reg(CFG_POINTS_IN_USE, CFG_DATA_W'(points));
    write_reg(CFG_DIFFUSION_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_MAX_ITERATIONS, CFG_DATA_W'(sweep_cap));
    write_reg(CFG_RESIDUAL_TOLERANCE, CFG_DATA_W'(tol));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  // Mostly moderate temperatures, sometimes the full signed range.
  function automatic logic signed [EXT_TEMP_W-1:0] rand_temp();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
  endfunction

  // Random setting: small grids with few sweeps keep runs short.
  task automatic random_setting();
    logic [POINTS_W-1:0] points;
    logic [SWEEP_W-1:0]  sweep_cap;
    logic [TOL_W-1:0]    tol;
    case ($urandom_range(9))
      0:       points = 7'd64;
      1:       points = $urandom_range(1) ? POINTS_W'($urandom_range(2))
                                          : POINTS_W'($urandom_range(127, 65));
      default: points = POINTS_W'($urandom_range(16, 3));
    endcase
    sweep_cap = (points > 16 || points < 3) ? SWEEP_W'($urandom_range(8, 1))
                                            : SWEEP_W'($urandom_range(30, 1));
    case ($urandom_range(2))
      0:       tol = '0;
      1:       tol = $urandom_range(5000);
      default: tol = $urandom;
    endcase
    set_grid(points, GAIN_W'($urandom_range(32768)), sweep_cap, tol);
  endtask

  // A phase of random runs under one idle pattern.
  task automatic random_phase(input int sender_pct, input int receiver_pct);
    drain_results();
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
    repeat (4) begin
      random_setting();
      repeat (4) send_request(rand_temp(), rand_temp());
    end
  endtask

  // Stimulus.
  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CFG_POINTS_IN_USE;
    cfg_data_i         = '0;
    boundary_req.valid = 1'b0;
    boundary_req.data  = '0;
    hold_off_armed     = 1'b0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    quiet_cycles       = 0;
    runs_sent          = 0;
    settings_used      = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: a flat zero grid settles after one sweep.
    send_request(32'sd0, 32'sd0);

    // Smallest grid, largest stable gain, one sweep, boundary extremes.
    set_grid(7'd3, 16'd32768, 16'd1, 32'd0);
    send_request(32'sd0, 32'sd0);
    send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_request(32'sh8000_0000, 32'sh8000_0000);
    send_request(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(32'sh8000_0000, 32'sh7FFF_FFFF);

    // Point count below the minimum and an unstable gain that saturates.
    set_grid(7'd0, 16'hFFFF, 16'd6, 32'd0);
    send_request(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_request(rand_temp(), rand_temp());

    // Point count above the maximum, widest sweep limit, tolerance at top.
    set_grid(7'd127, 16'd16384, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(32'sd0, 32'sd0);

    // Zero sweep limit returns the starting grid unconverged.
    set_grid(7'd64, 16'd0, 16'd0, 32'd66);
    send_request(32'sd1234, -32'sd5678);
    send_request(32'sh7FFF_FFFF, 32'sh8000_0000);

    // Zero gain never changes anything, and a zero tolerance is never met.
    set_grid(7'd64, 16'd0, 16'd3, 32'd0);
    send_request(32'sh0001_0000, -32'sh0001_0000);

    // Half-unit products round away from zero in both directions.
    set_grid(7'd5, 16'd32768, 16'd40, 32'd66);
    send_request(32'sd1, 32'sd0);
    send_request(-32'sd1, 32'sd0);
    send_request(32'sd3, -32'sd3);
    send_request(32'sh0001_0000, 32'sd0);

    // Random runs: no idling, sender idle, receiver stalling, both.
    random_phase(0, 0);
    random_phase(85, 0);
    random_phase(0, 85);
    random_phase(18, 18);

    // Back pressure: results held off while requests keep coming, then a
    // full pause of the sender until the block has emptied.
    set_grid(7'd16, 16'd20000, 16'd10, 32'd100);
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_off_armed = 1'b1;
    repeat (4) send_request(rand_temp(), rand_temp());
    drain_results();
    repeat (3) send_request(rand_temp(), rand_temp());
    random_phase(0, 0);

    // Wind down and give the verdict.
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (points_pending != 0) begin
      $display("%0t: %0d expected grid points never arrived", $time, points_pending);
    end
    $display("Summary: %0d runs under %0d register settings, %0d grid points checked.",
             runs_sent, settings_used, points_checked);
    $display("Idle patterns: none, sender, receiver, both, and a %0d-cycle result hold-off.",
             HOLD_OFF_CYCLES);
    if (mismatch_count == 0 && points_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
